@@ hw/rtl/ecd_pkg.sv @@
// ecd_pkg: constants and helpers for the epoch-seconds to civil-date pipeline
// reciprocals are worked out at elaboration from the divisors below
// no dependencies
`default_nettype none

package ecd_pkg;

  // seconds to days: 86400 = 2^7 * 675, the power of two is taken off as a shift
  localparam int unsigned SecsShift   = 7;
  localparam int unsigned DayBiasExp  = 23;
  localparam int unsigned DayRecipExp = 34;
  localparam logic [9:0]  DayDiv      = 10'd675;
  // 675 * 2^23, keeps the day quotient non-negative
  localparam logic [33:0] DayBias     = 34'(64'd675 << DayBiasExp);
  localparam logic [24:0] DayRecip    = 25'((64'd1 << DayRecipExp) / 64'd675);

  // day numbers shifted to 0000-03-01 and biased by whole eras
  localparam logic [17:0] EraDays     = 18'd146097;
  localparam logic [6:0]  EraBias     = 7'd40;
  localparam logic [15:0] EraYears    = 16'd400;
  localparam logic [24:0] DnBias      =
    25'((64'd1 << DayBiasExp) - 64'd719468 - 64'd40 * 64'd146097);
  localparam int unsigned EraRecipExp = 24;
  localparam logic [6:0]  EraRecip    = 7'((64'd1 << EraRecipExp) / 64'd146097);

  // year of era
  localparam logic [17:0] Days4Yr     = 18'd1460;
  localparam logic [17:0] Days100Yr   = 18'd36524;
  localparam logic [17:0] DaysEraEnd  = 18'd146096;
  localparam logic [17:0] DaysYear    = 18'd365;
  localparam int unsigned YrRecipExp  = 18;
  localparam logic [7:0]  Recip1460   = 8'((64'd1 << YrRecipExp) / 64'd1460);
  localparam logic [9:0]  Recip365    = 10'((64'd1 << YrRecipExp) / 64'd365);

  // month of the march-based year
  localparam logic [10:0] MonthSpan   = 11'd153;
  localparam int unsigned MpRecipExp  = 16;
  localparam logic [8:0]  Recip153    = 9'((64'd1 << MpRecipExp) / 64'd153);
  localparam logic [3:0]  MpJanuary   = 4'd10;

  // first day of year (march based) of each month index
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/epoch_seconds_to_civil_date.sv @@
// epoch_seconds_to_civil_date: seconds since 1970-01-01 to proleptic gregorian date
// stream in, stream out, eighteen register stages
// depends on ecd_pkg
`default_nettype none

// Converts a 40-bit signed count of seconds since 1970-01-01 UTC into year, month and
// day of the proleptic Gregorian calendar. One timestamp is taken every cycle while the
// output side does not stall. Each result passes through a chain of constant divisions
// (by 86400, by the 146097-day era, by 1460 and 365 for the year of era, by 153 for the
// month), each done as a reciprocal multiply followed by one compare-and-subtract
// correction over its own stages. A stall on the output fills empty stages first and
// only then holds off the input. A count of exactly zero gives a result with valid_res
// low and year, month and day at zero.

module epoch_seconds_to_civil_date
  import ecd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // [39:0] seconds
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] year, [19:16] month, [24:20] day,
                                           // [31:25] zero
  output logic             m_axis_tuser    // [0] valid_res
);

  localparam int NS = 18;

  logic [NS:1] v_q;
  logic [NS:1] en;
  logic        zero_q [1:NS-1];

  // stage payloads
  logic [33:0] u1_q, u2_q, u3_q;
  logic [41:0] phi2_q, plo2_q, phi2_d, plo2_d;
  logic [58:0] sum3;
  logic [24:0] q3_q, q3_d, q4_q;
  logic [10:0] r4_q, r4_d;
  logic [23:0] w5_q, w5_d, w6_q;
  logic [30:0] pe6_q, pe6_d;
  logic [6:0]  qe7_q, qe7_d, erap8_q, erap8_d;
  logic [18:0] re7_q, re7_d;
  logic        era_cy;
  logic [17:0] doe8_d;
  logic [17:0] doe_q [8:14];
  logic [15:0] era_m;
  logic [15:0] eb9_d;
  logic [15:0] eb_q [9:17];
  logic [25:0] p9_q, p9_d;
  logic [2:0]  c36_9_q, c36_9_d, c36_10_q;
  logic        c146_9_q, c146_9_d, c146_10_q;
  logic [7:0]  q10_q, q10_d;
  logic [11:0] r10_q, r10_d;
  logic [17:0] n11_q, n11_d, n12_q;
  logic [27:0] p12_q, p12_d;
  logic [9:0]  q13_q, q13_d, r13_q, r13_d;
  logic [8:0]  yoe14_d;
  logic [8:0]  yoe_q [14:17];
  logic [1:0]  c100;
  logic [17:0] yr_days;
  logic [8:0]  doy15_d;
  logic [8:0]  doy_q [15:17];
  logic [10:0] x16_q, x16_d;
  logic [19:0] p16_q, p16_d;
  logic [3:0]  q17_q, q17_d;
  logic [8:0]  r17_q, r17_d;
  logic [3:0]  mp18;
  logic [3:0]  month_d;
  logic [4:0]  day_d;
  logic [15:0] year_d;
  logic        res_valid_q;
  logic [15:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;

  // a stage may load when it or any stage after it is empty, or the output moves
  for (genvar k = 1; k <= NS; k++) begin : g_en
    assign en[k] = m_axis_tready | ~(&v_q[NS:k]);
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = v_q[NS];
  assign m_axis_tdata  = {7'd0, day_q, month_q, year_q};
  assign m_axis_tuser  = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    // days = floor(seconds / 86400) as a reciprocal product split in two halves
    phi2_d  = 42'(u1_q[33:17]) * 42'(DayRecip);
    plo2_d  = 42'(u1_q[16:0]) * 42'(DayRecip);
    sum3    = (59'(phi2_q) << 17) + 59'(plo2_q);
    q3_d    = sum3[58:34];
    r4_d    = 11'(u3_q - 34'(q3_q) * 34'(DayDiv));
    w5_d    = 24'(q4_q + 25'(r4_q >= 11'(DayDiv)) - DnBias);

    // era and day of era
    pe6_d   = 31'(w5_q) * 31'(EraRecip);
    qe7_d   = pe6_q[30:24];
    re7_d   = 19'(w6_q - 24'(24'(qe7_d) * 24'(EraDays)));
    era_cy  = re7_q >= 19'(EraDays);
    erap8_d = qe7_q + 7'(era_cy);
    doe8_d  = era_cy ? 18'(re7_q - 19'(EraDays)) : 18'(re7_q);

    // year of era
    era_m    = 16'(erap8_q) - 16'(EraBias);
    eb9_d    = 16'(32'(era_m) * 32'(EraYears));
    p9_d     = 26'(doe_q[8]) * 26'(Recip1460);
    c36_9_d  = 3'(doe_q[8] >= Days100Yr) + 3'(doe_q[8] >= 18'(2 * Days100Yr))
             + 3'(doe_q[8] >= 18'(3 * Days100Yr)) + 3'(doe_q[8] >= DaysEraEnd);
    c146_9_d = doe_q[8] == DaysEraEnd;
    q10_d    = p9_q[25:18];
    r10_d    = 12'(doe_q[9] - 18'(18'(q10_d) * Days4Yr));
    n11_d    = doe_q[10] - 18'(q10_q) - 18'(r10_q >= 12'(Days4Yr))
             + 18'(c36_10_q) - 18'(c146_10_q);
    p12_d    = 28'(n11_q) * 28'(Recip365);
    q13_d    = p12_q[27:18];
    r13_d    = 10'(n12_q - 18'(18'(q13_d) * DaysYear));
    yoe14_d  = 9'(q13_q + 10'(r13_q >= 10'(DaysYear)));

    // day of the march-based year
    c100    = 2'(yoe_q[14] >= 9'd100) + 2'(yoe_q[14] >= 9'd200)
            + 2'(yoe_q[14] >= 9'd300);
    yr_days = 18'(18'(yoe_q[14]) * DaysYear) + 18'(yoe_q[14][8:2]) - 18'(c100);
    doy15_d = 9'(doe_q[14] - yr_days);

    // month index, then month, day and year
    x16_d   = 11'(11'(doy_q[15]) * 11'd5 + 11'd2);
    p16_d   = 20'(x16_d) * 20'(Recip153);
    q17_d   = p16_q[19:16];
    r17_d   = 9'(x16_q - 11'(11'(q17_d) * MonthSpan));
    mp18    = q17_q + 4'(r17_q >= 9'(MonthSpan));
    day_d   = 5'(doy_q[17] - month_start(mp18) + 9'd1);
    month_d = (mp18 < MpJanuary) ? 4'(mp18 + 4'd3) : 4'(mp18 - 4'd9);
    year_d  = eb_q[17] + 16'(yoe_q[17]) + 16'(month_d <= 4'd2);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      zero_q[1] <= s_axis_tdata == '0;
      // floor by 128, then bias so the remaining division is unsigned
      u1_q      <= {s_axis_tdata[39], s_axis_tdata[39:SecsShift]} + DayBias;
    end
    for (int k = 2; k < NS; k++) begin
      if (en[k]) begin
        zero_q[k] <= zero_q[k-1];
      end
    end
    if (en[2]) begin
      phi2_q <= phi2_d;
      plo2_q <= plo2_d;
      u2_q   <= u1_q;
    end
    if (en[3]) begin
      q3_q <= q3_d;
      u3_q <= u2_q;
    end
    if (en[4]) begin
      q4_q <= q3_q;
      r4_q <= r4_d;
    end
    if (en[5]) begin
      w5_q <= w5_d;
    end
    if (en[6]) begin
      pe6_q <= pe6_d;
      w6_q  <= w5_q;
    end
    if (en[7]) begin
      qe7_q <= qe7_d;
      re7_q <= re7_d;
    end
    if (en[8]) begin
      erap8_q  <= erap8_d;
      doe_q[8] <= doe8_d;
    end
    for (int k = 9; k <= 14; k++) begin
      if (en[k]) begin
        doe_q[k] <= doe_q[k-1];
      end
    end
    if (en[9]) begin
      eb_q[9]  <= eb9_d;
      p9_q     <= p9_d;
      c36_9_q  <= c36_9_d;
      c146_9_q <= c146_9_d;
    end
    for (int k = 10; k <= 17; k++) begin
      if (en[k]) begin
        eb_q[k] <= eb_q[k-1];
      end
    end
    if (en[10]) begin
      q10_q     <= q10_d;
      r10_q     <= r10_d;
      c36_10_q  <= c36_9_q;
      c146_10_q <= c146_9_q;
    end
    if (en[11]) begin
      n11_q <= n11_d;
    end
    if (en[12]) begin
      p12_q <= p12_d;
      n12_q <= n11_q;
    end
    if (en[13]) begin
      q13_q <= q13_d;
      r13_q <= r13_d;
    end
    if (en[14]) begin
      yoe_q[14] <= yoe14_d;
    end
    for (int k = 15; k <= 17; k++) begin
      if (en[k]) begin
        yoe_q[k] <= yoe_q[k-1];
      end
    end
    if (en[15]) begin
      doy_q[15] <= doy15_d;
    end
    for (int k = 16; k <= 17; k++) begin
      if (en[k]) begin
        doy_q[k] <= doy_q[k-1];
      end
    end
    if (en[16]) begin
      x16_q <= x16_d;
      p16_q <= p16_d;
    end
    if (en[17]) begin
      q17_q <= q17_d;
      r17_q <= r17_d;
    end
    if (en[NS]) begin
      // a zero count carries no date
      res_valid_q <= !zero_q[NS-1];
      year_q      <= zero_q[NS-1] ? '0 : year_d;
      month_q     <= zero_q[NS-1] ? '0 : month_d;
      day_q       <= zero_q[NS-1] ? '0 : day_d;
    end
  end

  // a no-date result carries all-zero fields
  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("no-date result with non-zero fields");

  // a dated result has a month and a day in range
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[19:16] != 4'd0 && m_axis_tdata[19:16] <= 4'd12 &&
      m_axis_tdata[24:20] != 5'd0)
    else $error("month or day out of range");

  // year of era and day of year stay inside one era and one year
  a_era_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && !zero_q[NS-1] |-> yoe_q[17] <= 9'd399 && doy_q[17] <= 9'd365)
    else $error("year of era or day of year out of range");

endmodule

`default_nettype wire
